FILE: src/slcp_pkg.sv
// Shared types, character codes and reply tables for the serial line command parser.
`timescale 1ns / 1ps
`default_nettype none
package slcp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP_RD,
    ST_CMP_CHK,
    ST_EMIT,
    ST_ECHO_WAIT
  } slcp_state_t;

  typedef enum logic [1:0] {
    RPL_ON,
    RPL_OFF,
    RPL_ECHO
  } slcp_reply_t;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam int unsigned CMD_ON_LEN  = 6;
  localparam int unsigned CMD_OFF_LEN = 7;
  localparam int unsigned REP_ON_LEN  = 8;
  localparam int unsigned REP_OFF_LEN = 9;
  localparam int unsigned HEAD_LEN    = 10;

  function automatic logic [7:0] cmd_on_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = "L";
      3'd1:    c = "E";
      3'd2:    c = "D";
      3'd3:    c = "=";
      3'd4:    c = "O";
      3'd5:    c = "N";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cmd_off_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = "L";
      3'd1:    c = "E";
      3'd2:    c = "D";
      3'd3:    c = "=";
      3'd4:    c = "O";
      3'd5:    c = "F";
      3'd6:    c = "F";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rep_on_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "L";
      4'd1:    c = "E";
      4'd2:    c = "D";
      4'd3:    c = " ";
      4'd4:    c = "O";
      4'd5:    c = "N";
      4'd6:    c = CHAR_CR;
      4'd7:    c = CHAR_LF;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rep_off_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "L";
      4'd1:    c = "E";
      4'd2:    c = "D";
      4'd3:    c = " ";
      4'd4:    c = "O";
      4'd5:    c = "F";
      4'd6:    c = "F";
      4'd7:    c = CHAR_CR;
      4'd8:    c = CHAR_LF;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] head_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "Y";
      4'd1:    c = "o";
      4'd2:    c = "u";
      4'd3:    c = " ";
      4'd4:    c = "s";
      4'd5:    c = "a";
      4'd6:    c = "i";
      4'd7:    c = "d";
      4'd8:    c = ":";
      4'd9:    c = " ";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: src/serial_line_command_parser_unit.sv
// Serial line command parser: line store, command compare and reply sequencer.
// Ordinary byte: stored, no reply. Line end: stored characters are compared one at a time,
// each in a read and a check state (only for 6- or 7-byte lines, up to 7, stopping at the
// first mismatch); then reply bytes are loaded as the sink frees, each echoed store byte
// after its own RAM read; input ready is low until the last reply byte is loaded.
// Synchronous active-low reset clears fill count, LED level and sequencer, not the store.
`timescale 1ns / 1ps
`default_nettype none
module serial_line_command_parser_unit #(
  parameter int LINE_CAPACITY = 15
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] tx_byte, [8] led_level, [15:9] zero
  output logic             out_tlast   // last_of_reply
);

  import slcp_pkg::*;

  localparam int FILL_W = $clog2(LINE_CAPACITY + 1);
  localparam int ADDR_W = $clog2(LINE_CAPACITY);
  localparam int POS_W  = $clog2(LINE_CAPACITY + 13);

  slcp_state_t         state_r, state_nxt;
  slcp_reply_t         kind_r, kind_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [2:0]          idx_r, idx_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                led_r, led_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_led_r, out_led_nxt;

  logic                in_fire, is_eol, is_cmd_len, is_on_len, out_free;
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [7:0]          ram_rdata;
  logic [7:0]          expect_char;
  logic                cmp_miss, cmp_last;
  logic [POS_W-1:0]    fill_pos, store_off, last_pos;
  logic                store_sel, emit_last;
  logic [7:0]          table_byte;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign is_eol     = (in_tdata == CHAR_CR) || (in_tdata == CHAR_LF);
  assign is_on_len  = (fill_r == FILL_W'(CMD_ON_LEN));
  assign is_cmd_len = is_on_len || (fill_r == FILL_W'(CMD_OFF_LEN));
  assign out_free   = !out_valid_r || out_tready;

  assign expect_char = is_on_len ? cmd_on_char(idx_r) : cmd_off_char(idx_r);
  assign cmp_miss    = (ram_rdata != expect_char);
  assign cmp_last    = ((FILL_W'(idx_r) + FILL_W'(1)) == fill_r);

  assign fill_pos  = POS_W'(fill_r) + POS_W'(HEAD_LEN);
  assign store_off = pos_r - POS_W'(HEAD_LEN);
  assign store_sel = (kind_r == RPL_ECHO) && (pos_r >= POS_W'(HEAD_LEN)) && (pos_r < fill_pos);

  always_comb begin
    unique case (kind_r)
      RPL_ON:   last_pos = POS_W'(REP_ON_LEN - 1);
      RPL_OFF:  last_pos = POS_W'(REP_OFF_LEN - 1);
      default:  last_pos = fill_pos + POS_W'(1);
    endcase
  end
  assign emit_last = (pos_r == last_pos);

  always_comb begin
    unique case (kind_r)
      RPL_ON:  table_byte = rep_on_char(pos_r[3:0]);
      RPL_OFF: table_byte = rep_off_char(pos_r[3:0]);
      default: begin
        if (pos_r < POS_W'(HEAD_LEN)) begin
          table_byte = head_char(pos_r[3:0]);
        end else if (pos_r == fill_pos) begin
          table_byte = CHAR_CR;
        end else begin
          table_byte = CHAR_LF;
        end
      end
    endcase
  end

  assign ram_we    = in_fire && !is_eol && (fill_r < FILL_W'(LINE_CAPACITY));
  assign ram_waddr = fill_r[ADDR_W-1:0];
  assign ram_re    = (state_r == ST_CMP_RD) || ((state_r == ST_EMIT) && store_sel);
  assign ram_raddr = (state_r == ST_CMP_RD) ? ADDR_W'(idx_r) : store_off[ADDR_W-1:0];

  slcp_ram #(
    .WIDTH (8),
    .DEPTH (LINE_CAPACITY)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && is_eol) begin
          state_nxt = is_cmd_len ? ST_CMP_RD : ST_EMIT;
        end
      end
      ST_CMP_RD:  state_nxt = ST_CMP_CHK;
      ST_CMP_CHK: begin
        if (cmp_miss || cmp_last) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_CMP_RD;
        end
      end
      ST_EMIT: begin
        if (store_sel) begin
          state_nxt = ST_ECHO_WAIT;
        end else if (out_free && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ECHO_WAIT: begin
        if (out_free) begin
          state_nxt = ST_EMIT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt      = kind_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    led_nxt       = led_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_led_nxt   = out_led_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ram_we) begin
          fill_nxt = fill_r + FILL_W'(1);
        end
        if (in_fire && is_eol) begin
          idx_nxt = 3'd0;
          pos_nxt = '0;
          kind_nxt = RPL_ECHO;
        end
      end
      ST_CMP_CHK: begin
        if (cmp_miss) begin
          kind_nxt = RPL_ECHO;
        end else if (cmp_last) begin
          kind_nxt = is_on_len ? RPL_ON : RPL_OFF;
          led_nxt  = is_on_len;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      ST_EMIT: begin
        if (!store_sel && out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = table_byte;
          out_last_nxt  = emit_last;
          out_led_nxt   = led_r;
          pos_nxt       = pos_r + POS_W'(1);
          if (emit_last) begin
            fill_nxt = '0;
          end
        end
      end
      ST_ECHO_WAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = ram_rdata;
          out_last_nxt  = 1'b0;
          out_led_nxt   = led_r;
          pos_nxt       = pos_r + POS_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      led_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      led_r       <= led_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r     <= kind_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_led_r  <= out_led_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_led_r, out_byte_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

FILE: src/slcp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module slcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 15
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: src/slcp_checker.sv
// Port-level checker for the serial line command parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module slcp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [7:0]  in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast
);

  import slcp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled reply byte changed");

  a_busy_mid_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("request taken while a reply is in progress");

  a_eol_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && ((in_tdata == CHAR_CR) || (in_tdata == CHAR_LF)) |=> !in_tready)
    else $error("line end did not start a reply");

  a_plain_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata != CHAR_CR) && (in_tdata != CHAR_LF)
    |=> in_tready && !(out_tvalid && !$past(out_tvalid)))
    else $error("ordinary byte produced a reply");

endmodule

bind serial_line_command_parser_unit slcp_checker u_slcp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
